>>> rtl/core/swfrm_pkg.sv
// Package for the sliding-window frame-rate meter.
// Holds shared widths, the controller state type, the ring request and the reset pattern.
// Depends on nothing.
package swfrm_pkg;

  // Field widths fixed by the interface.
  localparam int DUR_W = 12;
  localparam int FPS_W = 18;
  localparam int CNT_W = 10;
  localparam int IDX_W = 8;

  // Default configuration.
  localparam int WINDOW_DEF          = 32;
  localparam int UPDATE_INTERVAL_DEF = 30;

  // Saturated rate: 1000 frames per second with 8 fraction bits.
  localparam int RATE_MAX   = 256000;
  localparam int MS_Q8      = 1000 * 256;
  localparam int DUR_MAX    = 4095;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_EMIT
  } state_t;

  // One access to the duration ring. Address is at most 8 bits wide.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    logic [DUR_W-1:0] wdata;
  } ring_req_t;

  // Reset value of ring entry idx: 17 when idx mod 3 is 0, else 16.
  // Since 4 mod 3 is 1, idx mod 3 equals the sum of its base-4 digits mod 3.
  function automatic logic [DUR_W-1:0] reset_duration(input logic [IDX_W-1:0] idx);
    logic [3:0] dsum;
    logic       div3;
    dsum = {2'b00, idx[1:0]} + {2'b00, idx[3:2]} + {2'b00, idx[5:4]} + {2'b00, idx[7:6]};
    case (dsum)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: div3 = 1'b1;
      default:                       div3 = 1'b0;
    endcase
    return div3 ? DUR_W'(17) : DUR_W'(16);
  endfunction

endpackage

>>> rtl/core/sliding_window_frame_rate_meter.sv
// Top level of the sliding-window frame-rate meter.
// Controller, pointer, frame counter and running sum; uses swfrm_ring and swfrm_div.
// Depends on swfrm_pkg.
//
//   channel  signals                       payload
//   frame    frame_valid / frame_stall     frame_ms (12 bits)
//   rate     rate_valid  / rate_stall      fps_q8 (18 bits), fps_updated (1 bit)
//
// An item that does not recompute the rate goes from ST_IDLE through ST_READ to ST_EMIT.
// An item that recomputes it also waits in ST_DIV while the serial divider forms
// the quotient bit by bit, and the rate is stored in rate_hold when it is done.
// Reset clears pointer, counter, held rate and ring valid bits at once; it presets the sum.
// The next item is accepted once the result has moved into the output register;
// a stall on the rate side holds that register until taken; the next result waits in ST_EMIT.
module sliding_window_frame_rate_meter #(
  parameter int WINDOW          = swfrm_pkg::WINDOW_DEF,
  parameter int UPDATE_INTERVAL = swfrm_pkg::UPDATE_INTERVAL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        frame_valid,
  output logic                        frame_stall,
  input  logic [swfrm_pkg::DUR_W-1:0] frame_ms,
  output logic                        rate_valid,
  input  logic                        rate_stall,
  output logic [swfrm_pkg::FPS_W-1:0] fps_q8,
  output logic                        fps_updated
);

  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W     = $clog2(WINDOW * swfrm_pkg::DUR_MAX + 1);
  localparam int SUM_RESET = 16 * WINDOW + (WINDOW + 2) / 3;

  swfrm_pkg::state_t              state, state_next;
  logic [PTR_W-1:0]               wp, wp_next;
  logic [swfrm_pkg::CNT_W-1:0]    cnt, cnt_next, cnt_inc;
  logic                           upd, upd_next;
  logic [swfrm_pkg::DUR_W-1:0]    dur;
  logic [SUM_W-1:0]               sum;
  logic [swfrm_pkg::FPS_W-1:0]    rate_hold;
  logic [swfrm_pkg::DUR_W-1:0]    old_dur;
  logic [swfrm_pkg::FPS_W-1:0]    div_rate;
  logic                           div_done;
  logic                           div_start;
  logic                           accept;
  logic                           load_out;
  swfrm_pkg::ring_req_t           req;

  // Pointer advance and frame count for the item being accepted.
  always_comb begin
    wp_next  = (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + 1'b1;
    cnt_inc  = cnt + 1'b1;
    upd_next = cnt_inc >= swfrm_pkg::CNT_W'(UPDATE_INTERVAL);
    cnt_next = upd_next ? '0 : cnt_inc;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      swfrm_pkg::ST_IDLE: if (frame_valid) state_next = swfrm_pkg::ST_READ;
      swfrm_pkg::ST_READ: state_next = upd ? swfrm_pkg::ST_DIV : swfrm_pkg::ST_EMIT;
      swfrm_pkg::ST_DIV:  if (div_done) state_next = swfrm_pkg::ST_EMIT;
      swfrm_pkg::ST_EMIT: if (!rate_valid || !rate_stall) state_next = swfrm_pkg::ST_IDLE;
      default:            state_next = swfrm_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    frame_stall = 1'b1;
    accept      = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    req.rd_en   = 1'b0;
    req.wr_en   = 1'b0;
    req.addr    = swfrm_pkg::IDX_W'(wp);
    req.wdata   = dur;
    unique case (state)
      swfrm_pkg::ST_IDLE: begin
        frame_stall = 1'b0;
        accept      = frame_valid;
        req.rd_en   = frame_valid;
        req.addr    = swfrm_pkg::IDX_W'(wp_next);
      end
      swfrm_pkg::ST_READ: begin
        req.wr_en = 1'b1;
        div_start = upd;
      end
      swfrm_pkg::ST_DIV: begin
      end
      swfrm_pkg::ST_EMIT: begin
        load_out = !rate_valid || !rate_stall;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= swfrm_pkg::ST_IDLE;
      wp         <= '0;
      cnt        <= '0;
      sum        <= SUM_W'(SUM_RESET);
      rate_hold  <= '0;
      rate_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        wp  <= wp_next;
        cnt <= cnt_next;
      end
      // The divider latched the old sum in this same cycle.
      if (state == swfrm_pkg::ST_READ) begin
        sum <= sum + SUM_W'(dur) - SUM_W'(old_dur);
      end
      if (div_done) begin
        rate_hold <= div_rate;
      end
      if (load_out) begin
        rate_valid <= 1'b1;
      end else if (!rate_stall) begin
        rate_valid <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      dur <= frame_ms;
      upd <= upd_next;
    end
    if (load_out) begin
      fps_q8      <= rate_hold;
      fps_updated <= upd;
    end
  end

  swfrm_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .old_dur (old_dur)
  );

  swfrm_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (sum),
    .done  (div_done),
    .rate  (div_rate)
  );

endmodule

>>> rtl/core/swfrm_ring.sv
// Ring of the last WINDOW frame durations for the frame-rate meter.
// A memory with a registered read port and one valid bit per entry.
// Depends on swfrm_pkg.
module swfrm_ring #(
  parameter int WINDOW = swfrm_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swfrm_pkg::ring_req_t          req,
  output logic [swfrm_pkg::DUR_W-1:0]   old_dur
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [swfrm_pkg::DUR_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]           written;
  logic [swfrm_pkg::DUR_W-1:0] rd_data;
  logic                        rd_written;
  logic [PTR_W-1:0]            rd_addr;
  logic [PTR_W-1:0]            addr;

  assign addr = req.addr[PTR_W-1:0];

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data <= mem[addr];
      rd_addr <= addr;
    end
  end

  // Entry valid bits: an entry never written reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written <= written[addr];
      end
    end
  end

  assign old_dur = rd_written ? rd_data
                 : swfrm_pkg::reset_duration(swfrm_pkg::IDX_W'(rd_addr));

endmodule

>>> rtl/core/swfrm_div.sv
// Bit-serial restoring divider for the frame-rate meter.
// Divides the constant WINDOW*256000 by the window sum, one quotient bit per cycle.
// Depends on swfrm_pkg.
module swfrm_div #(
  parameter int  WINDOW = swfrm_pkg::WINDOW_DEF,
  localparam int SUM_W  = $clog2(WINDOW * swfrm_pkg::DUR_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [SUM_W-1:0]            den,
  output logic                        done,
  output logic [swfrm_pkg::FPS_W-1:0] rate
);

  localparam int DIVIDEND = WINDOW * swfrm_pkg::MS_Q8;
  localparam int DIV_W    = $clog2(DIVIDEND + 1);
  localparam int STEP_W   = $clog2(DIV_W + 1);
  localparam int REM_W    = SUM_W + 1;

  logic [DIV_W-1:0]  dnd;
  logic [DIV_W-1:0]  quo;
  logic [SUM_W-1:0]  dvs;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem[SUM_W-1:0], dnd[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dnd <= DIV_W'(DIVIDEND);
      dvs <= den;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dnd <= {dnd[DIV_W-2:0], 1'b0};
      rem <= fits ? (trial - {1'b0, dvs}) : trial;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  // A zero divisor yields an all-ones quotient, which saturates as well.
  assign rate = (quo > DIV_W'(swfrm_pkg::RATE_MAX)) ? swfrm_pkg::FPS_W'(swfrm_pkg::RATE_MAX)
                                                    : quo[swfrm_pkg::FPS_W-1:0];

endmodule

>>> bench/sliding_window_frame_rate_meter_tb.sv
// Self-checking testbench for the sliding-window frame-rate meter.
// Predicts every rate item from its own ring, sum, pointer and frame counter.
// Depends on swfrm_pkg and sliding_window_frame_rate_meter.
module sliding_window_frame_rate_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN      = swfrm_pkg::WINDOW_DEF;
  localparam int UPD      = swfrm_pkg::UPDATE_INTERVAL_DEF;
  localparam int PTR_W    = $clog2(WIN);
  localparam int DUR_W    = swfrm_pkg::DUR_W;
  localparam int FPS_W    = swfrm_pkg::FPS_W;
  localparam int RATE_MAX = swfrm_pkg::RATE_MAX;
  localparam int MS_Q8    = swfrm_pkg::MS_Q8;
  localparam int MAX_DUR  = swfrm_pkg::DUR_MAX;

  // Kinds of duration bursts in the random part.
  typedef enum int {
    DUR_ZERO,
    DUR_TINY,
    DUR_MAX,
    DUR_NEAR_MAX,
    DUR_TYPICAL,
    DUR_FULL
  } dur_mode_t;

  typedef struct {
    logic [FPS_W-1:0] fps;
    logic             updated;
  } rate_item_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             frame_valid = 1'b0;
  logic             frame_stall;
  logic [DUR_W-1:0] frame_ms = '0;
  logic             rate_valid;
  logic             rate_stall = 1'b0;
  logic [FPS_W-1:0] fps_q8;
  logic             fps_updated;

  // Idling controls and error count.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;
  int unsigned errors        = 0;

  // Predicted meter state.
  logic [DUR_W-1:0] dur_ring [WIN];
  logic [19:0]      dur_sum;
  logic [PTR_W-1:0] wr_ptr;
  int unsigned      frame_count;
  logic [FPS_W-1:0] held_rate;

  rate_item_t pending_rates [$];

  sliding_window_frame_rate_meter i_dut (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_ms    (frame_ms),
    .rate_valid  (rate_valid),
    .rate_stall  (rate_stall),
    .fps_q8      (fps_q8),
    .fps_updated (fps_updated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rate in Q.8 from a window sum, saturating at 1000 frames per second.
  function automatic logic [FPS_W-1:0] rate_from_sum(input logic [19:0] total);
    longint unsigned q;
    if (total == 0) return FPS_W'(RATE_MAX);
    q = (longint'(WIN) * MS_Q8) / longint'(total);
    if (q > RATE_MAX) q = RATE_MAX;
    return FPS_W'(q);
  endfunction

  task automatic reset_prediction();
    dur_sum = '0;
    for (int i = 0; i < WIN; i++) begin
      dur_ring[i] = (i % 3 == 0) ? DUR_W'(17) : DUR_W'(16);
      dur_sum += dur_ring[i];
    end
    wr_ptr      = '0;
    frame_count = 0;
    held_rate   = '0;
  endtask

  // Advance the predicted state by one accepted frame and queue its rate item.
  task automatic predict_frame(input logic [DUR_W-1:0] dur);
    rate_item_t item;
    item.updated = 1'b0;
    wr_ptr = (wr_ptr == PTR_W'(WIN - 1)) ? '0 : wr_ptr + 1'b1;
    frame_count++;
    if (frame_count >= UPD) begin
      frame_count  = 0;
      held_rate    = rate_from_sum(dur_sum);
      item.updated = 1'b1;
    end
    dur_sum = dur_sum + dur - dur_ring[wr_ptr];
    dur_ring[wr_ptr] = dur;
    item.fps = held_rate;
    pending_rates.push_back(item);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d, wanted %0d", what, got, want);
  endtask

  // Offer one frame item, with random idle cycles in front, and wait until it is taken.
  task automatic send_frame(input logic [DUR_W-1:0] dur);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 50) gap++;
    if (gap != 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_ms    <= dur;
    do @(posedge clk); while (frame_stall);
    predict_frame(dur);
  endtask

  // Stop offering and wait until every predicted item has been taken.
  task automatic drain_rates();
    frame_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration(input dur_mode_t m);
    case (m)
      DUR_ZERO:     return '0;
      DUR_TINY:     return DUR_W'($urandom_range(1));
      DUR_MAX:      return DUR_W'(MAX_DUR);
      DUR_NEAR_MAX: return DUR_W'($urandom_range(MAX_DUR, 4000));
      DUR_TYPICAL:  return DUR_W'($urandom_range(40, 10));
      default:      return DUR_W'($urandom_range(MAX_DUR));
    endcase
  endfunction

  // Extremes of the duration field and a few bit patterns, no idling.
  task automatic test_directed();
    logic [DUR_W-1:0] vals [25] = '{
      12'd0, 12'd4095, 12'd1, 12'd4094, 12'h800, 12'h7FF, 12'h555, 12'hAAA,
      12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd17, 12'd16,
      12'd16, 12'd33, 12'd1, 12'hF0F, 12'h0F0, 12'd100, 12'd1000, 12'd3000,
      12'd4095};
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (vals[i]) send_frame(vals[i]);
  endtask

  // Bursts of one duration kind each; long zero and tiny bursts reach the
  // zero-sum and rate-above-range cases, max and near-max bursts the lowest rates.
  task automatic test_random_bursts(input int unsigned n, input int unsigned idle,
                                    input int unsigned stall);
    int unsigned sent;
    int unsigned len;
    dur_mode_t   m;
    send_idle_pct = idle;
    stall_pct     = stall;
    sent = 0;
    while (sent < n) begin
      m   = dur_mode_t'($urandom_range(DUR_FULL));
      len = $urandom_range(70, 20);
      if (len > n - sent) len = n - sent;
      repeat (len) begin
        send_frame(pick_duration(m));
        sent++;
      end
    end
  endtask

  // Receiver holds off for a long stretch so the meter stalls its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 400;
    repeat (40) send_frame(pick_duration(DUR_FULL));
    drain_rates();
  endtask

  // Receiver stall: random per cycle, or a counted long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      rate_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_req != 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      rate_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      rate_stall <= 1'b1;
    end else begin
      rate_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each taken rate item with the oldest prediction.
  always @(posedge clk) begin
    rate_item_t want;
    if (!rst && rate_valid && !rate_stall) begin
      if (pending_rates.size() == 0) begin
        report_mismatch("rate item with no frame pending", fps_q8, 0);
      end else begin
        want = pending_rates.pop_front();
        if (fps_q8 !== want.fps) report_mismatch("fps_q8", fps_q8, want.fps);
        if (fps_updated !== want.updated)
          report_mismatch("fps_updated", fps_updated, want.updated);
      end
    end
  end

  initial begin
    reset_prediction();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_bursts(120, 0, 0);
    test_random_bursts(120, 51, 0);
    test_random_bursts(120, 0, 51);
    test_random_bursts(120, 21, 21);
    test_backpressure();
    stall_pct = 0;
    drain_rates();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sliding_window_frame_rate_meter.f
rtl/core/swfrm_pkg.sv
rtl/core/swfrm_ring.sv
rtl/core/swfrm_div.sv
rtl/core/sliding_window_frame_rate_meter.sv
bench/sliding_window_frame_rate_meter_tb.sv
